FILE: rtl/apt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types, codes and helpers of the attention priority table.
// ----------------------------------------------------------------------------
package apt_pkg;

  // default sizing
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned TICK_RATE_DEF   = 1000;

  // command codes
  typedef enum logic [3:0] {
    CMD_ALLOC   = 4'd0,
    CMD_FREE    = 4'd1,
    CMD_PRIO    = 4'd2,
    CMD_SLICE   = 4'd3,
    CMD_THINK   = 4'd4,
    CMD_INFER   = 4'd5,
    CMD_LEARN   = 4'd6,
    CMD_UPDATE  = 4'd7,
    CMD_DECAY   = 4'd8,
    CMD_STATS   = 4'd9,
    CMD_FINDMAX = 4'd10,
    CMD_SPREAD  = 4'd11,
    CMD_BOOST   = 4'd12,
    CMD_SLEEP   = 4'd13,
    CMD_RESUME  = 4'd14
  } cmd_e;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // entry modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_THINK  = 3'd1;
  localparam logic [2:0] MODE_REASON = 3'd2;
  localparam logic [2:0] MODE_LEARN  = 3'd3;
  localparam logic [2:0] MODE_WAIT   = 3'd4;

  // one table entry
  typedef struct packed {
    logic        occ;
    logic [15:0] sa;
    logic [15:0] la;
    logic [2:0]  mode;
    logic [31:0] inf;
    logic [31:0] cyc;
  } entry_t;

  // broadcast operation seen by every cell
  typedef enum logic [1:0] {
    BC_NONE  = 2'd0,
    BC_WRITE = 2'd1,
    BC_DECAY = 2'd2
  } bc_op_e;

  typedef struct packed {
    bc_op_e      op;
    logic        t_en;
    logic [15:0] t_sa;
    entry_t      ent;
  } bcast_t;

  // running totals handed from cell to cell during a walk
  typedef struct packed {
    logic               vld;
    logic [31:0]        inf;
    logic [31:0]        cyc;
    logic signed [16:0] best;
    logic [5:0]         idx;
    logic               found;
  } chain_t;

  // signed divide by ten, truncated toward zero, magnitude below 2^19
  function automatic logic signed [19:0] div10(input logic signed [19:0] x);
    logic        neg;
    logic [19:0] a;
    logic [35:0] p;
    logic [19:0] q;
    logic [19:0] r;
    neg = x[19];
    a   = neg ? 20'(-x) : 20'(x);
    p   = 36'(a) * 36'(52428);
    q   = 20'(p >> 19);
    r   = a - ((q << 3) + (q << 1));
    if (r >= 20'd10) q = q + 20'd1;
    return neg ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: rtl/apt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_cell
// One table entry: local update, read-out and one step of the walk chain.
// ----------------------------------------------------------------------------
module apt_cell import apt_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bcast_t        bc_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [AW-1:0] t_addr_i,
  input  logic [AW-1:0] rd_a_addr_i,
  input  logic [AW-1:0] rd_b_addr_i,
  input  chain_t        chain_i,
  output chain_t        chain_o,
  output entry_t        rd_a_o,
  output entry_t        rd_b_o
);

  localparam logic [AW-1:0] MyIdx = AW'(INDEX);

  logic        occ_q;
  logic [15:0] sa_q;
  logic [15:0] la_q;
  logic [2:0]  mode_q;
  logic [31:0] inf_q;
  logic [31:0] cyc_q;
  chain_t      chain_q;
  chain_t      chain_d;
  entry_t      ent;
  logic        hit_w;
  logic        hit_t;

  assign hit_w = (bc_i.op == BC_WRITE) && (wr_addr_i == MyIdx);
  assign hit_t = (bc_i.op == BC_WRITE) && bc_i.t_en && (t_addr_i == MyIdx);

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (hit_w) begin
      occ_q <= bc_i.ent.occ;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (hit_w) begin
      sa_q   <= bc_i.ent.sa;
      la_q   <= bc_i.ent.la;
      mode_q <= bc_i.ent.mode;
      inf_q  <= bc_i.ent.inf;
      cyc_q  <= bc_i.ent.cyc;
    end else if (hit_t) begin
      sa_q <= bc_i.t_sa;
    end else if (bc_i.op == BC_DECAY && occ_q && $signed(sa_q) > 16'sd0) begin
      sa_q <= sa_q - 16'd1;
    end
  end

  // read-out, masked so the top can or the cells together
  assign ent = '{occ: occ_q, sa: sa_q, la: la_q, mode: mode_q, inf: inf_q, cyc: cyc_q};
  assign rd_a_o = (rd_a_addr_i == MyIdx) ? ent : '0;
  assign rd_b_o = (rd_b_addr_i == MyIdx) ? ent : '0;

  // walk step: add own counters, compete for the maximum
  always_comb begin
    chain_d = chain_i;
    if (chain_i.vld && occ_q) begin
      chain_d.inf = chain_i.inf + inf_q;
      chain_d.cyc = chain_i.cyc + cyc_q;
      if ($signed({sa_q[15], sa_q}) > chain_i.best) begin
        chain_d.best  = $signed({sa_q[15], sa_q});
        chain_d.idx   = 6'(INDEX);
        chain_d.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

FILE: rtl/attention_priority_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attention_priority_table
// Table of attention entries held in a row of cells, one command per request.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, command..amount_long| request into block
//  out     | out_valid_o/out_ready_i, status..used_count| result out of block
//
//  single-entry commands: after accept, read, execute, then load the result
//  stats and find max: a walk lies between execute and load; the running
//  totals step through one cell per cycle along the chain
//  reset clears occupancy, used count, state, valid and walk chain; no clearing pass
//  a stalled result stays in the output register; the next request is taken
//  meanwhile and waits before loading it
module attention_priority_table import apt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned TICK_RATE   = TICK_RATE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         command_i,
  input  logic [5:0]         slot_i,
  input  logic [5:0]         other_slot_i,
  input  logic signed [15:0] amount_i,
  input  logic signed [15:0] amount_long_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [5:0]         result_slot_o,
  output logic signed [16:0] value_o,
  output logic [31:0]        total_inferences_o,
  output logic [31:0]        total_cycles_o,
  output logic [6:0]         used_count_o
);

  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (UW > 6) ? UW : 6;
  localparam logic [UW-1:0] UsedMax = UW'(MAX_ENTRIES);
  localparam logic signed [16:0] SliceHi  = 17'(TICK_RATE / 50);
  localparam logic signed [16:0] SliceMid = 17'(TICK_RATE / 100);
  localparam logic signed [16:0] SliceLo  = 17'(TICK_RATE / 200);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_WALK, ST_PUSH
  } state_e;

  state_e             state_q;
  logic [UW-1:0]      used_q;
  logic [3:0]         cmd_q;
  logic [5:0]         slot_q;
  logic [5:0]         oslot_q;
  logic signed [15:0] amt_q;
  logic signed [15:0] amtl_q;
  entry_t             rd_s_q;
  entry_t             rd_t_q;
  logic [1:0]         p_status_q;
  logic [5:0]         p_slot_q;
  logic signed [16:0] p_value_q;
  logic [31:0]        p_inf_q;
  logic [31:0]        p_cyc_q;
  logic [6:0]         p_used_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [5:0]         rslot_q;
  logic signed [16:0] value_q;
  logic [31:0]        inf_q;
  logic [31:0]        cyc_q;
  logic [6:0]         used_out_q;

  // execute-cycle signals
  bcast_t             bc;
  logic [AW-1:0]      wr_addr;
  logic [1:0]         x_status;
  logic [5:0]         x_slot;
  logic signed [16:0] x_value;
  logic               x_walk;
  logic               x_alloc;
  logic               ok;
  logic signed [16:0] sum_s;
  logic signed [16:0] sum_l;
  logic signed [19:0] sa_ext;
  logic signed [19:0] q_sleep;
  logic signed [19:0] q_boost;

  chain_t chain_w [MAX_ENTRIES+1];
  entry_t rd_a_w  [MAX_ENTRIES];
  entry_t rd_b_w  [MAX_ENTRIES];
  entry_t rd_a;
  entry_t rd_b;

  // row of cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    apt_cell #(.INDEX(i), .AW(AW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .bc_i       (bc),
      .wr_addr_i  (wr_addr),
      .t_addr_i   (AW'(oslot_q)),
      .rd_a_addr_i(AW'(slot_q)),
      .rd_b_addr_i(AW'(oslot_q)),
      .chain_i    (chain_w[i]),
      .chain_o    (chain_w[i+1]),
      .rd_a_o     (rd_a_w[i]),
      .rd_b_o     (rd_b_w[i])
    );
  end

  // walk entry point
  always_comb begin
    chain_w[0]       = '0;
    chain_w[0].vld   = x_walk;
    chain_w[0].best  = -17'sd1;
  end

  // gather the addressed entries
  always_comb begin
    rd_a = '0;
    rd_b = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_a = rd_a | rd_a_w[i];
      rd_b = rd_b | rd_b_w[i];
    end
  end

  // command execution
  always_comb begin
    bc        = '0;
    bc.op     = BC_NONE;
    bc.ent    = rd_s_q;
    wr_addr   = AW'(slot_q);
    x_status  = STAT_DONE;
    x_slot    = '0;
    x_value   = '0;
    x_walk    = 1'b0;
    x_alloc   = 1'b0;
    ok        = rd_s_q.occ;
    sum_s     = $signed({rd_s_q.sa[15], rd_s_q.sa}) + 17'(amt_q);
    sum_l     = $signed({rd_s_q.la[15], rd_s_q.la}) + 17'(amtl_q);
    sa_ext    = 20'($signed(rd_s_q.sa));
    q_sleep   = div10((sa_ext <<< 3) + sa_ext);
    q_boost   = div10(20'(amt_q));
    if (state_q == ST_EXEC) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (used_q >= UsedMax) begin
            x_status = STAT_NONE;
          end else begin
            x_alloc = 1'b1;
            bc.op   = BC_WRITE;
            wr_addr = AW'(used_q);
            bc.ent  = '{occ: 1'b1, sa: '0, la: '0, mode: MODE_IDLE, inf: '0, cyc: '0};
            x_slot  = 6'(used_q);
          end
        end
        CMD_FREE: begin
          if (ok) begin
            bc.op      = BC_WRITE;
            bc.ent.occ = 1'b0;
          end else x_status = STAT_EMPTY;
        end
        CMD_PRIO: begin
          if (ok) begin
            x_value = $signed({rd_s_q.sa[15], rd_s_q.sa});
            if (rd_s_q.mode == MODE_THINK) x_value = x_value + 17'sd10;
            else if (rd_s_q.mode == MODE_REASON) x_value = x_value + 17'sd20;
          end else x_status = STAT_EMPTY;
        end
        CMD_SLICE: begin
          if (ok) begin
            if ($signed(rd_s_q.sa) > 16'sd100) x_value = SliceHi;
            else if ($signed(rd_s_q.sa) > 16'sd50) x_value = SliceMid;
            else x_value = SliceLo;
          end else begin
            x_status = STAT_EMPTY;
            x_value  = SliceMid;
          end
        end
        CMD_THINK, CMD_INFER, CMD_LEARN: begin
          if (ok) begin
            bc.op       = BC_WRITE;
            bc.ent.mode = (cmd_q == CMD_THINK) ? MODE_THINK :
                          (cmd_q == CMD_INFER) ? MODE_REASON : MODE_LEARN;
            if (cmd_q == CMD_INFER) bc.ent.inf = rd_s_q.inf + 32'd1;
            bc.ent.cyc  = rd_s_q.cyc + 32'd1;
          end else x_status = STAT_EMPTY;
        end
        CMD_UPDATE: begin
          if (ok) begin
            bc.op     = BC_WRITE;
            bc.ent.sa = (sum_s < 0) ? 16'd0 : (sum_s > 17'sd32767) ? 16'd32767
                                                                     : sum_s[15:0];
            bc.ent.la = (sum_l < 0) ? 16'd0 : (sum_l > 17'sd32767) ? 16'd32767
                                                                     : sum_l[15:0];
          end else x_status = STAT_EMPTY;
        end
        CMD_DECAY: begin
          bc.op = BC_DECAY;
        end
        CMD_STATS, CMD_FINDMAX: begin
          x_walk = 1'b1;
        end
        CMD_SPREAD: begin
          if (ok && rd_t_q.occ) begin
            if ($signed(rd_s_q.sa) >= amt_q && slot_q != oslot_q) begin
              bc.op     = BC_WRITE;
              bc.ent.sa = rd_s_q.sa - amt_q;
              bc.t_en   = 1'b1;
              bc.t_sa   = rd_t_q.sa + amt_q;
            end
          end else x_status = STAT_EMPTY;
        end
        CMD_BOOST: begin
          if (ok) begin
            bc.op     = BC_WRITE;
            bc.ent.sa = rd_s_q.sa + amt_q;
            bc.ent.la = rd_s_q.la + q_boost[15:0];
          end else x_status = STAT_EMPTY;
        end
        CMD_SLEEP: begin
          if (ok) begin
            bc.op       = BC_WRITE;
            bc.ent.mode = MODE_WAIT;
            bc.ent.sa   = q_sleep[15:0];
          end else x_status = STAT_EMPTY;
        end
        CMD_RESUME: begin
          if (ok) begin
            bc.op       = BC_WRITE;
            bc.ent.mode = MODE_IDLE;
          end else x_status = STAT_EMPTY;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, request capture and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result taken and nothing new to load this cycle
      if (out_valid_q && out_ready_i && state_q != ST_PUSH) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            slot_q  <= slot_i;
            oslot_q <= other_slot_i;
            amt_q   <= amount_i;
            amtl_q  <= amount_long_i;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          rd_s_q  <= rd_a;
          rd_t_q  <= rd_b;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          p_status_q <= x_status;
          p_slot_q   <= x_slot;
          p_value_q  <= x_value;
          p_inf_q    <= '0;
          p_cyc_q    <= '0;
          p_used_q   <= '0;
          if (x_alloc) used_q <= used_q + UW'(1);
          state_q <= x_walk ? ST_WALK : ST_PUSH;
        end
        ST_WALK: begin
          if (chain_w[MAX_ENTRIES].vld) begin
            if (cmd_q == CMD_STATS) begin
              p_inf_q  <= chain_w[MAX_ENTRIES].inf;
              p_cyc_q  <= chain_w[MAX_ENTRIES].cyc;
              p_used_q <= 7'(used_q);
            end else if (chain_w[MAX_ENTRIES].found) begin
              p_slot_q <= chain_w[MAX_ENTRIES].idx;
            end else begin
              p_status_q <= STAT_NONE;
            end
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= p_status_q;
            rslot_q     <= p_slot_q;
            value_q     <= p_value_q;
            inf_q       <= p_inf_q;
            cyc_q       <= p_cyc_q;
            used_out_q  <= p_used_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign result_slot_o      = rslot_q;
  assign value_o            = value_q;
  assign total_inferences_o = inf_q;
  assign total_cycles_o     = cyc_q;
  assign used_count_o       = used_out_q;

endmodule

FILE: rtl/apt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks of the attention priority table, bound to the top level.
// ----------------------------------------------------------------------------
module apt_checker import apt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [5:0]         result_slot_o,
  input logic signed [16:0] value_o,
  input logic [31:0]        total_inferences_o,
  input logic [31:0]        total_cycles_o,
  input logic [6:0]         used_count_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(value_o) && $stable(result_slot_o))
    else $error("stalled result changed");

  // one request in flight: busy right after accepting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // a failed request names no slot and carries no totals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_DONE |-> result_slot_o == 6'd0
      && total_inferences_o == 32'd0 && total_cycles_o == 32'd0)
    else $error("failed request carries data");

  // status is one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status");

  // a used count only ever comes with a done status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && used_count_o != 7'd0 |-> status_o == STAT_DONE)
    else $error("used count on failed request");

endmodule

bind attention_priority_table apt_checker u_apt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .result_slot_o     (result_slot_o),
  .value_o           (value_o),
  .total_inferences_o(total_inferences_o),
  .total_cycles_o    (total_cycles_o),
  .used_count_o      (used_count_o)
);
